FILE: hdl/bdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants of the BCD date/time converter
// Request and response words, the split-count field bundle, the reciprocal
// constants used for division by fixed divisors, and BCD helper functions.
// ----------------------------------------------------------------------------
package bdc_pkg;

	// request codes
	localparam logic [1:0] REQ_UNIX        = 2'd0;
	localparam logic [1:0] REQ_PACKED      = 2'd1;
	localparam logic [1:0] REQ_FROM_PACKED = 2'd2;

	localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
	localparam logic [11:0] SEC_PER_HOUR   = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN    = 6'd60;
	localparam logic [8:0]  DAYS_PER_YEAR  = 9'd372;
	localparam logic [4:0]  DAYS_PER_MONTH = 5'd31;
	localparam logic [8:0]  DAYS_PER_CYEAR = 9'd365;

	// Rounded-up reciprocals: n * R >> k equals n / d exactly while n * d < 2**k.
	// days  = (count >> 7) / 675, n < 2**25, k = 35
	localparam logic [25:0] DAY_RECIP   = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
	// years = (days >> 2) / 93, n < 2**14, k = 21
	localparam logic [14:0] YEAR_RECIP  = 15'(((1 << 21) + 92) / 93);
	// hours = (tod >> 4) / 225, n < 2**13, k = 21
	localparam logic [13:0] HOUR_RECIP  = 14'(((1 << 21) + 224) / 225);
	// month = days_in_year / 31, n < 2**9, k = 14
	localparam logic [9:0]  MONTH_RECIP = 10'(((1 << 14) + 30) / 31);
	// minutes = (sec_in_hour >> 2) / 15, n < 2**10, k = 14
	localparam logic [10:0] MIN_RECIP   = 11'(((1 << 14) + 14) / 15);
	// tens = v / 10, n < 2**7, k = 11
	localparam logic [7:0]  TENS_RECIP  = 8'(((1 << 11) + 9) / 10);

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] date_word;
		logic [31:0] time_word;
		logic [31:0] packed_in;
	} req_t;

	typedef struct packed {
		logic [31:0] seconds_out;
		logic [31:0] date_out;
		logic [31:0] time_out;
		logic        fields_ok;
	} rsp_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       year_ok;
	} split_t;

	function automatic logic [7:0] bcd_decode(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'b0, b[7:4]};
		return 8'((hi << 3) + (hi << 1) + {4'b0, b[3:0]});
	endfunction

	function automatic logic [7:0] bcd_encode(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  t7;
		logic [6:0]  ones;
		p    = 15'(v) * 15'(TENS_RECIP);
		tens = p[14:11];
		t7   = {3'b0, tens};
		ones = v - 7'((t7 << 3) + (t7 << 1));
		return {tens, ones[3:0]};
	endfunction

	// days of the months before the given one, non-leap year
	function automatic logic [8:0] cum_days(input logic [3:0] mo);
		logic [8:0] d;
		unique case (mo)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: hdl/bdc_count_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_count_split: packed count to calendar fields
// Six-stage divider chain by fixed divisors (day, year, hour, month, minute),
// each quotient from a rounded-up reciprocal product, each remainder from a
// multiply and subtract in the following stage. Advances every cycle.
// ----------------------------------------------------------------------------
module bdc_count_split import bdc_pkg::*; (
	input  logic        clk,
	input  logic [31:0] packed_in,
	output split_t      split
);

	// stage 1: whole days
	logic [50:0] day_prod;
	logic [31:0] pk_s1;
	logic [15:0] days_s1;

	assign day_prod = 51'(packed_in[31:7]) * 51'(DAY_RECIP);

	always_ff @(posedge clk) begin
		pk_s1   <= packed_in;
		days_s1 <= day_prod[50:35];
	end

	// stage 2: time of day and years
	logic [31:0] day_sec;
	logic [28:0] year_prod;
	logic [16:0] tod_s2;
	logic [7:0]  yr_s2;
	logic [15:0] days_s2;

	assign day_sec   = 32'(days_s1) * 32'(SEC_PER_DAY);
	assign year_prod = 29'(days_s1[15:2]) * 29'(YEAR_RECIP);

	always_ff @(posedge clk) begin
		tod_s2  <= 17'(pk_s1 - day_sec);
		yr_s2   <= year_prod[28:21];
		days_s2 <= days_s1;
	end

	// stage 3: hours and days within the year
	logic [26:0] hour_prod;
	logic [15:0] year_days;
	logic [16:0] tod_s3;
	logic [4:0]  hr_s3;
	logic [8:0]  rdays_s3;
	logic [7:0]  yr_s3;

	assign hour_prod = 27'(tod_s2[16:4]) * 27'(HOUR_RECIP);
	assign year_days = 16'(yr_s2) * 16'(DAYS_PER_YEAR);

	always_ff @(posedge clk) begin
		tod_s3   <= tod_s2;
		hr_s3    <= hour_prod[25:21];
		rdays_s3 <= 9'(days_s2 - year_days);
		yr_s3    <= yr_s2;
	end

	// stage 4: seconds within the hour and month
	logic [16:0] hour_sec;
	logic [18:0] month_prod;
	logic [11:0] mstod_s4;
	logic [3:0]  mo0_s4;
	logic [8:0]  rdays_s4;
	logic [4:0]  hr_s4;
	logic [7:0]  yr_s4;

	assign hour_sec   = 17'(hr_s3) * 17'(SEC_PER_HOUR);
	assign month_prod = 19'(rdays_s3) * 19'(MONTH_RECIP);

	always_ff @(posedge clk) begin
		mstod_s4 <= 12'(tod_s3 - hour_sec);
		mo0_s4   <= month_prod[17:14];
		rdays_s4 <= rdays_s3;
		hr_s4    <= hr_s3;
		yr_s4    <= yr_s3;
	end

	// stage 5: minutes and day of month
	logic [20:0] min_prod;
	logic [8:0]  month_days;
	logic [11:0] mstod_s5;
	logic [5:0]  mi_s5;
	logic [4:0]  dy0_s5;
	logic [3:0]  mo0_s5;
	logic [4:0]  hr_s5;
	logic [7:0]  yr_s5;

	assign min_prod   = 21'(mstod_s4[11:2]) * 21'(MIN_RECIP);
	assign month_days = 9'(mo0_s4) * 9'(DAYS_PER_MONTH);

	always_ff @(posedge clk) begin
		mstod_s5 <= mstod_s4;
		mi_s5    <= min_prod[19:14];
		dy0_s5   <= 5'(rdays_s4 - month_days);
		mo0_s5   <= mo0_s4;
		hr_s5    <= hr_s4;
		yr_s5    <= yr_s4;
	end

	// stage 6: seconds, one-based day and month, two-digit year
	logic [11:0] min_sec;
	split_t      split_s6;

	assign min_sec = 12'(mi_s5) * 12'(SEC_PER_MIN);

	always_ff @(posedge clk) begin
		split_s6.second  <= 6'(mstod_s5 - min_sec);
		split_s6.minute  <= mi_s5;
		split_s6.hour    <= hr_s5;
		split_s6.day     <= dy0_s5 + 5'd1;
		split_s6.month   <= mo0_s5 + 4'd1;
		split_s6.year_ok <= (yr_s5 <= 8'd99);
		split_s6.year    <= (yr_s5 >= 8'd100) ? 7'(yr_s5 - 8'd100) : yr_s5[6:0];
	end

	assign split = split_s6;

endmodule

FILE: hdl/bcd_datetime_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_datetime_converter_unit: BCD RTC words to and from seconds counts
// Converts BCD date/time words to Unix seconds or a 31-day-month packed
// count, or splits a packed count back into BCD date/time words.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high; busy stays low because the
// seven-stage pipeline never holds. Each response appears with done high for
// exactly one cycle, in request order, one per cycle at full rate. The
// pipeline depth is set by the divider chain of the count split (six stages)
// plus the BCD encode and output register. The receiver cannot stall, so
// done is never held off.
// ----------------------------------------------------------------------------
module bcd_datetime_converter_unit import bdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] dw;
		logic [31:0] tw;
		logic        good;
	} ctx_t;

	logic   accept;
	logic   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	ctx_t   ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;
	split_t split;
	rsp_t   rsp_s7;

	// pipeline always advances
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	bdc_count_split u_split (
		.clk       (clk),
		.packed_in (req.packed_in),
		.split     (split)
	);

	// stage 1: BCD decode and range check
	logic [7:0] yr_d, mo_d, dy_d, hr_d, mi_d, sc_d;
	logic [7:0] yr_s1, mo_s1, dy_s1, hr_s1, mi_s1, sc_s1;
	logic       good_d;

	always_comb begin
		yr_d   = bcd_decode(req.date_word[31:24]);
		mo_d   = bcd_decode(req.date_word[23:16]);
		dy_d   = bcd_decode(req.date_word[15:8]);
		hr_d   = bcd_decode(req.time_word[31:24]);
		mi_d   = bcd_decode(req.time_word[23:16]);
		sc_d   = bcd_decode(req.time_word[15:8]);
		good_d = (yr_d <= 8'd99) && (mo_d >= 8'd1) && (mo_d <= 8'd12) &&
		         (dy_d >= 8'd1) && (dy_d <= 8'd31) && (hr_d <= 8'd23) &&
		         (mi_d <= 8'd59) && (sc_d <= 8'd59);
	end

	always_ff @(posedge clk) begin
		ctx_s1.mode <= req.req_type;
		ctx_s1.dw   <= req.date_word;
		ctx_s1.tw   <= req.time_word;
		ctx_s1.good <= good_d;
		yr_s1       <= yr_d;
		mo_s1       <= mo_d;
		dy_s1       <= dy_d;
		hr_s1       <= hr_d;
		mi_s1       <= mi_d;
		sc_s1       <= sc_d;
	end

	// stage 2: year days, days within the year, time of day
	logic [15:0] yr16, yrdays_d;
	logic [8:0]  mddays_d;
	logic        leap;
	logic [15:0] yrdays_s2;
	logic [8:0]  mddays_s2;
	logic [16:0] tod_s2;

	always_comb begin
		yr16 = 16'(yr_s1[6:0]);
		leap = (yr_s1[1:0] == 2'd0) && (mo_s1 > 8'd2);
		if (ctx_s1.mode == REQ_UNIX) begin
			// 2000 + yr - 1970 whole years, leap days from (y - 1969) / 4
			yrdays_d = 16'((yr16 + 16'd30) * 16'(DAYS_PER_CYEAR)) +
			           16'((yr16 + 16'd31) >> 2);
			mddays_d = cum_days(mo_s1[3:0]) + 9'(leap) + 9'(dy_s1[4:0]) - 9'd1;
		end else begin
			yrdays_d = 16'(yr16 * 16'(DAYS_PER_YEAR));
			mddays_d = 9'((9'(mo_s1[3:0]) - 9'd1) * 9'(DAYS_PER_MONTH)) +
			           9'(dy_s1[4:0]) - 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2    <= ctx_s1;
		yrdays_s2 <= yrdays_d;
		mddays_s2 <= mddays_d;
		tod_s2    <= 17'(17'(hr_s1[4:0]) * 17'(SEC_PER_HOUR)) +
		             17'(17'(mi_s1[5:0]) * 17'(SEC_PER_MIN)) + 17'(sc_s1[5:0]);
	end

	// stage 3: total days
	logic [15:0] days_s3;
	logic [16:0] tod_s3;

	always_ff @(posedge clk) begin
		ctx_s3  <= ctx_s2;
		days_s3 <= yrdays_s2 + 16'(mddays_s2);
		tod_s3  <= tod_s2;
	end

	// stage 4: seconds count, wraps at 32 bits
	logic [31:0] sec_s4, sec_s5, sec_s6;

	always_ff @(posedge clk) begin
		ctx_s4 <= ctx_s3;
		sec_s4 <= 32'(32'(days_s3) * 32'(SEC_PER_DAY)) + 32'(tod_s3);
	end

	// stages 5 and 6: hold while the count split finishes
	always_ff @(posedge clk) begin
		ctx_s5 <= ctx_s4;
		sec_s5 <= sec_s4;
		ctx_s6 <= ctx_s5;
		sec_s6 <= sec_s5;
	end

	// stage 7: BCD encode and select by request code
	rsp_t rsp_d;

	always_comb begin
		rsp_d.seconds_out = 32'd0;
		rsp_d.date_out    = ctx_s6.dw;
		rsp_d.time_out    = ctx_s6.tw;
		rsp_d.fields_ok   = 1'b0;
		unique case (ctx_s6.mode)
			REQ_UNIX, REQ_PACKED: begin
				rsp_d.seconds_out = ctx_s6.good ? sec_s6 : 32'd0;
				rsp_d.fields_ok   = ctx_s6.good;
			end
			REQ_FROM_PACKED: begin
				rsp_d.date_out  = {bcd_encode(split.year),
				                   bcd_encode(7'(split.month)),
				                   bcd_encode(7'(split.day)),
				                   ctx_s6.dw[7:0]};
				rsp_d.time_out  = {bcd_encode(7'(split.hour)),
				                   bcd_encode(7'(split.minute)),
				                   bcd_encode(7'(split.second)),
				                   ctx_s6.tw[7:0]};
				rsp_d.fields_ok = split.year_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rsp_s7 <= rsp_d;
	end

	assign done = valid_s7;
	assign rsp  = rsp_s7;

	// a response always traces back to an earlier accepted request
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 7))
		else $error("response without a matching request");

	// spare bytes pass through in every mode
	a_spare_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.date_out[7:0] == $past(req.date_word[7:0], 7)) &&
		         (rsp.time_out[7:0] == $past(req.time_word[7:0], 7)))
		else $error("weekday or spare byte lost in the pipeline");

	// a failed check always gives a zero count
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.fields_ok) |-> (rsp.seconds_out == 32'd0))
		else $error("nonzero count with fields flagged bad");

	// count split never reports a count
	a_split_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(req.req_type, 7) == REQ_FROM_PACKED)) |->
		(rsp.seconds_out == 32'd0))
		else $error("count split produced a seconds value");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bcd_datetime_converter_unit
// Drives a short table of hand-picked words, then random words in phases with
// different sender gaps. Random words and table rows without a given response
// are converted by a local model of the converter, and each strobed response
// is compared field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;
	import bdc_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	// first packed count whose year no longer fits in two digits
	localparam int unsigned PACKED_SPAN = 32'd3214080000;
	localparam int IDLE_PLAN [4] = '{0, 48, 23, 0};
	localparam int WORDS_PER_PHASE = 280;
	localparam int DRAIN_CYCLES = 16;
	localparam int DRAIN_LIMIT = 1000;

	typedef struct packed {
		req_t req;
		logic typed;
		rsp_t want;
	} vector_t;

	localparam vector_t DIRECTED [25] = '{
		'{'{REQ_UNIX, 32'h00010106, 32'h00000000, 32'h0}, 1'b1,
			'{32'd946684800, 32'h00010106, 32'h00000000, 1'b1}},
		'{'{REQ_PACKED, 32'h00010100, 32'h000000FF, 32'h0}, 1'b1,
			'{32'd0, 32'h00010100, 32'h000000FF, 1'b1}},
		'{'{REQ_UNIX, 32'h99123107, 32'h235959FF, 32'hFFFFFFFF}, 1'b0, '0},
		'{'{REQ_PACKED, 32'h99123107, 32'h235959FF, 32'h0}, 1'b0, '0},
		// leap year, past February
		'{'{REQ_UNIX, 32'h04030100, 32'h00000000, 32'h0}, 1'b0, '0},
		'{'{REQ_UNIX, 32'h00022900, 32'h12345600, 32'h0}, 1'b0, '0},
		// day beyond the end of the month runs on into the next
		'{'{REQ_UNIX, 32'h01023100, 32'h12000000, 32'h0}, 1'b0, '0},
		'{'{REQ_PACKED, 32'h01023100, 32'h12000000, 32'h0}, 1'b0, '0},
		// nibbles above nine pass when the decoded value is in range
		'{'{REQ_UNIX, 32'h05011A00, 32'h0F3A0900, 32'h0}, 1'b0, '0},
		'{'{REQ_PACKED, 32'h24000105, 32'h12000000, 32'h0}, 1'b1,
			'{32'd0, 32'h24000105, 32'h12000000, 1'b0}},
		'{'{REQ_UNIX, 32'h24130105, 32'h12000000, 32'h0}, 1'b1,
			'{32'd0, 32'h24130105, 32'h12000000, 1'b0}},
		'{'{REQ_UNIX, 32'h24010005, 32'h12000000, 32'h0}, 1'b1,
			'{32'd0, 32'h24010005, 32'h12000000, 1'b0}},
		'{'{REQ_PACKED, 32'h24013205, 32'h12000000, 32'h0}, 1'b1,
			'{32'd0, 32'h24013205, 32'h12000000, 1'b0}},
		'{'{REQ_UNIX, 32'h24010105, 32'h24000000, 32'h0}, 1'b1,
			'{32'd0, 32'h24010105, 32'h24000000, 1'b0}},
		'{'{REQ_PACKED, 32'h24010105, 32'h005A0000, 32'h0}, 1'b1,
			'{32'd0, 32'h24010105, 32'h005A0000, 1'b0}},
		'{'{REQ_UNIX, 32'h24010105, 32'h00006000, 32'h0}, 1'b1,
			'{32'd0, 32'h24010105, 32'h00006000, 1'b0}},
		'{'{REQ_PACKED, 32'hA0010105, 32'h00000000, 32'h0}, 1'b1,
			'{32'd0, 32'hA0010105, 32'h00000000, 1'b0}},
		'{'{REQ_UNIX, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
			'{32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0}},
		'{'{REQ_FROM_PACKED, 32'hFFFFFFA5, 32'hFFFFFF5A, 32'h00000000}, 1'b1,
			'{32'd0, 32'h000101A5, 32'h0000005A, 1'b1}},
		// year overflow keeps the last two digits
		'{'{REQ_FROM_PACKED, 32'h000000A5, 32'h0000005A, 32'hFFFFFFFF}, 1'b1,
			'{32'd0, 32'h330818A5, 32'h0628155A, 1'b0}},
		'{'{REQ_FROM_PACKED, 32'h12345678, 32'h9ABCDEF0, 32'd3214079999}, 1'b0, '0},
		'{'{REQ_FROM_PACKED, 32'h12345678, 32'h9ABCDEF0, 32'd3214080000}, 1'b0, '0},
		'{'{REQ_FROM_PACKED, 32'h00000000, 32'h00000000, 32'h12345678}, 1'b0, '0},
		'{'{REQ_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
			'{32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0}},
		'{'{REQ_UNUSED, 32'h00000000, 32'h00000000, 32'h00000000}, 1'b1,
			'{32'd0, 32'h00000000, 32'h00000000, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	rsp_t pending_words [$];
	int errors = 0;
	int idle_pct = 0;

	bcd_datetime_converter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("bcd_datetime_converter_unit test failed");
		$finish;
	end

	function automatic int unsigned bcd_value(logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	function automatic logic [7:0] to_bcd(int unsigned v);
		return {4'((v / 10) % 10), 4'(v % 10)};
	endfunction

	function automatic rsp_t convert_word(req_t r);
		int unsigned yr, mo, dy, hr, mi, sc, tod, days, v;
		rsp_t o;
		o = '{seconds_out: 32'd0, date_out: r.date_word, time_out: r.time_word,
			fields_ok: 1'b0};
		if (r.req_type == REQ_UNIX || r.req_type == REQ_PACKED) begin
			yr = bcd_value(r.date_word[31:24]);
			mo = bcd_value(r.date_word[23:16]);
			dy = bcd_value(r.date_word[15:8]);
			hr = bcd_value(r.time_word[31:24]);
			mi = bcd_value(r.time_word[23:16]);
			sc = bcd_value(r.time_word[15:8]);
			if (yr <= 99 && mo >= 1 && mo <= 12 && dy >= 1 && dy <= 31 &&
					hr <= 23 && mi <= 59 && sc <= 59) begin
				tod = hr * 3600 + mi * 60 + sc;
				o.fields_ok = 1'b1;
				if (r.req_type == REQ_UNIX) begin
					// years since 1970, plus leap days counted from 1969
					days = 365 * (yr + 30) + (yr + 31) / 4;
					for (int m = 0; m + 1 < mo; m++)
						days += MONTH_LEN[m];
					if (yr % 4 == 0 && mo > 2)
						days += 1;
					days += dy - 1;
					o.seconds_out = days * 86400 + tod;
				end else begin
					o.seconds_out = tod + (dy - 1) * 86400 + (mo - 1) * 86400 * 31 +
						yr * 86400 * 372;
				end
			end
		end else if (r.req_type == REQ_FROM_PACKED) begin
			v = r.packed_in;
			sc = v % 60;
			v /= 60;
			mi = v % 60;
			v /= 60;
			hr = v % 24;
			v /= 24;
			dy = v % 31 + 1;
			v /= 31;
			mo = v % 12 + 1;
			yr = v / 12;
			o.fields_ok = (yr <= 99);
			yr %= 100;
			o.date_out = {to_bcd(yr), to_bcd(mo), to_bcd(dy), r.date_word[7:0]};
			o.time_out = {to_bcd(hr), to_bcd(mi), to_bcd(sc), r.time_word[7:0]};
		end
		return o;
	endfunction

	// in-range byte, now and then with a nibble above nine
	function automatic logic [7:0] field_byte(int unsigned lo, int unsigned hi);
		logic [7:0] b;
		if ($urandom_range(0, 4) != 0)
			return to_bcd($urandom_range(hi, lo));
		do
			b = 8'($urandom);
		while (bcd_value(b) < lo || bcd_value(b) > hi);
		return b;
	endfunction

	function automatic req_t make_request();
		req_t r;
		int unsigned kind;
		logic [7:0] fld [6];
		r.date_word = $urandom;
		r.time_word = $urandom;
		r.packed_in = $urandom;
		r.req_type = 2'($urandom_range(0, 1));
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			fld[0] = field_byte(0, 99);
			fld[1] = field_byte(1, 12);
			fld[2] = field_byte(1, 31);
			fld[3] = field_byte(0, 23);
			fld[4] = field_byte(0, 59);
			fld[5] = field_byte(0, 59);
			// spoil one field in some words
			if (kind >= 40)
				fld[$urandom_range(0, 5)] = 8'($urandom);
			r.date_word[31:8] = {fld[0], fld[1], fld[2]};
			r.time_word[31:8] = {fld[3], fld[4], fld[5]};
		end else if (kind < 85) begin
			r.req_type = REQ_FROM_PACKED;
			if (kind < 75)
				r.packed_in = $urandom_range(PACKED_SPAN - 1, 0);
		end else if (kind < 95) begin
			r.req_type = 2'($urandom);
		end else begin
			r.req_type = REQ_UNUSED;
		end
		return r;
	endfunction

	task automatic send_word(req_t r, rsp_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		pending_words.push_back(want);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (done === 1'b1) begin
			if (pending_words.size() == 0) begin
				$display("%0t: response with no word pending, actual %h", $time, rsp);
				errors++;
			end else begin
				want = pending_words.pop_front();
				check_field("seconds_out", want.seconds_out, rsp.seconds_out);
				check_field("date_out", want.date_out, rsp.date_out);
				check_field("time_out", want.time_out, rsp.time_out);
				check_field("fields_ok", 32'(want.fields_ok), 32'(rsp.fields_ok));
			end
		end
	end

	initial begin
		req_t r;
		int waited;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			send_word(DIRECTED[i].req,
				DIRECTED[i].typed ? DIRECTED[i].want : convert_word(DIRECTED[i].req));
		foreach (IDLE_PLAN[p]) begin
			idle_pct = IDLE_PLAN[p];
			repeat (WORDS_PER_PHASE) begin
				r = make_request();
				send_word(r, convert_word(r));
			end
		end
		start <= 1'b0;
		waited = 0;
		while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_words.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, pending_words.size());
			errors++;
		end
		if (errors == 0)
			$display("bcd_datetime_converter_unit test passed");
		else
			$display("bcd_datetime_converter_unit test failed");
		$finish;
	end

endmodule
